// ===== design/fccp_pkg.sv =====
// Shared types and constants of the content cache controller.
`timescale 1ns / 1ps
package fccp_pkg;

    localparam int ID_BITS     = 20;
    localparam int CLIENT_BITS = 8;
    localparam int CACHE_DEPTH = 128;
    localparam int CA_BITS     = 7;
    localparam int FILL_BITS   = 8;
    localparam int PEND_DEPTH  = 16;
    localparam int PA_BITS     = 4;
    localparam int PCNT_BITS   = 5;
    localparam int STAMP_BITS  = 16;
    localparam int CNT_BITS    = 32;
    localparam int MAX_RESULTS = 16;
    localparam int SIZE_BITS   = 8;
    localparam int SPAN_BITS   = 2;
    localparam int CIDX_BITS   = 2;
    localparam int CDATA_BITS  = 20;
    localparam int NCAND       = 5;
    localparam int OQ_DEPTH    = 4;
    localparam int OQ_BITS     = 2;

    localparam logic [CIDX_BITS-1:0] CFG_CACHE_SIZE = 2'd0;
    localparam logic [CIDX_BITS-1:0] CFG_PF_LIMIT   = 2'd1;
    localparam logic [CIDX_BITS-1:0] CFG_PF_SPAN    = 2'd2;

    localparam logic [SIZE_BITS-1:0]  CACHE_SIZE_RST = 8'd100;
    localparam logic [ID_BITS-1:0]    PF_LIMIT_RST   = 20'd101;
    localparam logic [SPAN_BITS-1:0]  PF_SPAN_RST    = 2'd2;

    localparam logic KIND_RESP  = 1'b0;
    localparam logic KIND_FETCH = 1'b1;

    typedef struct packed {
        logic                   is_arrival;
        logic [ID_BITS-1:0]     id;
        logic [CLIENT_BITS-1:0] client;
    } t_item;

    typedef struct packed {
        logic                   kind;
        logic [ID_BITS-1:0]     id;
        logic [CLIENT_BITS-1:0] dest;
        logic                   full;
        logic                   last;
        logic [CNT_BITS-1:0]    hits;
        logic [CNT_BITS-1:0]    accesses;
    } t_result;

    typedef struct packed {
        logic [SIZE_BITS-1:0] cache_size;
        logic [ID_BITS-1:0]   pf_limit;
        logic [SPAN_BITS-1:0] pf_span;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_HIT,
        ST_FETCH,
        ST_PSCAN,
        ST_ANSWER
    } t_state;

endpackage

// ===== design/fccp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fccp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/fccp_front.sv =====
// Front end: accepts and classifies input items into a two-entry queue.
`timescale 1ns / 1ps
module fccp_front
    import fccp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic                   i_action,
    input  logic [ID_BITS-1:0]     i_item_id,
    input  logic [CLIENT_BITS-1:0] i_client,
    output logic                   o_vld,
    output t_item                  o_item,
    input  logic                   i_take
);

    t_item      r_q [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_put, w_get;

    assign full   = (r_cnt == 2'd2);
    assign o_vld  = (r_cnt != 2'd0);
    assign o_item = r_q[r_rp];
    assign w_put  = push && !full;
    assign w_get  = i_take && o_vld;

    always_comb begin
        n_wp  = w_put ? !r_wp : r_wp;
        n_rp  = w_get ? !r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, w_put} - {1'b0, w_get};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (w_put) begin
            r_q[r_wp] <= '{is_arrival: i_action, id: i_item_id, client: i_client};
        end
    end

endmodule

// ===== design/fccp_outq.sv =====
// Result queue between the back end and the result port.
`timescale 1ns / 1ps
module fccp_outq
    import fccp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_put,
    input  t_result i_res,
    output logic    o_space,
    output logic    empty,
    input  logic    pop,
    output t_result o_res
);

    t_result              r_q [OQ_DEPTH];
    logic [OQ_BITS-1:0]   r_wp, r_rp;
    logic [OQ_BITS:0]     r_cnt, n_cnt;
    logic                 w_put, w_get;

    assign o_space = (r_cnt != OQ_BITS'(0) + (OQ_BITS+1)'(OQ_DEPTH));
    assign empty   = (r_cnt == '0);
    assign o_res   = r_q[r_rp];
    assign w_put   = i_put && o_space;
    assign w_get   = pop && !empty;

    always_comb begin
        n_cnt = r_cnt + {{OQ_BITS{1'b0}}, w_put} - {{OQ_BITS{1'b0}}, w_get};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_put) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_get) begin
                r_rp <= r_rp + 1'b1;
            end
        end
        if (w_put) begin
            r_q[r_wp] <= i_res;
        end
    end

endmodule

// ===== design/fccp_back.sv =====
// Back end: id store search, prefetch issue, pending table and answers.
`timescale 1ns / 1ps
module fccp_back
    import fccp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_vld,
    input  t_item   i_item,
    output logic    o_take,
    output logic    o_emit,
    output t_result o_res,
    input  logic    i_space
);

    t_state r_state, n_state;
    t_item  r_item, n_item;

    logic [CA_BITS-1:0]   r_head, n_head;
    logic [FILL_BITS-1:0] r_fill, n_fill;
    logic [CNT_BITS-1:0]  r_hits, n_hits;
    logic [CNT_BITS-1:0]  r_acc, n_acc;
    logic [FILL_BITS-1:0] r_sidx, n_sidx;
    logic                 r_rvld, n_rvld;
    logic [NCAND-1:0]     r_found, n_found;
    logic [NCAND-1:0]     r_mask, n_mask;
    logic                 r_full, n_full;

    logic [ID_BITS-1:0]     r_pid    [PEND_DEPTH];
    logic [CLIENT_BITS-1:0] r_pcl    [PEND_DEPTH];
    logic [STAMP_BITS-1:0]  r_pstamp [PEND_DEPTH];
    logic [PEND_DEPTH-1:0]  r_pvalid, n_pvalid;
    logic [STAMP_BITS-1:0]  r_nstamp, n_nstamp;
    logic [PA_BITS-1:0]     r_pidx, n_pidx;
    logic [PA_BITS-1:0]     r_best, n_best;
    logic [STAMP_BITS-1:0]  r_bage, n_bage;
    logic                   r_bfound, n_bfound;
    logic [PCNT_BITS-1:0]   r_matches, n_matches;
    logic [PCNT_BITS-1:0]   r_nans, n_nans;

    logic                 w_rec;
    logic [PA_BITS-1:0]   w_slot;
    logic                 w_ren, w_we;
    logic [CA_BITS-1:0]   w_raddr, w_waddr;
    logic [ID_BITS-1:0]   w_rdata;
    logic [ID_BITS-1:0]   w_cand [NCAND];
    logic [NCAND-1:0]     w_hitv, w_mk, w_low, w_rest;
    logic [SIZE_BITS-1:0] w_lim;
    logic                 w_pmatch, w_better, w_scan_end, w_ans_last;
    logic [STAMP_BITS-1:0] w_age;

    fccp_ram #(
        .WIDTH(ID_BITS),
        .DEPTH(CACHE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_item.id),
        .i_re    (w_ren),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_cand[0] = r_item.id;
        w_cand[1] = r_item.id - ID_BITS'(1);
        w_cand[2] = r_item.id - ID_BITS'(2);
        w_cand[3] = r_item.id + ID_BITS'(1);
        w_cand[4] = r_item.id + ID_BITS'(2);
        for (int k = 0; k < NCAND; k++) begin
            w_hitv[k] = r_rvld && (w_rdata == w_cand[k]);
        end
    end

    always_comb begin
        w_mk[0] = 1'b1;
        w_mk[1] = (i_cfg.pf_span >= 2'd1) && (r_item.id >= ID_BITS'(2)) && !r_found[1];
        w_mk[2] = (i_cfg.pf_span >= 2'd2) && (r_item.id >= ID_BITS'(3)) && !r_found[2];
        w_mk[3] = (i_cfg.pf_span >= 2'd1)
                  && (({1'b0, r_item.id} + (ID_BITS+1)'(1)) < {1'b0, i_cfg.pf_limit})
                  && !r_found[3];
        w_mk[4] = (i_cfg.pf_span >= 2'd2)
                  && (({1'b0, r_item.id} + (ID_BITS+1)'(2)) < {1'b0, i_cfg.pf_limit})
                  && !r_found[4];
    end

    always_comb begin
        w_low  = r_mask & (~r_mask + NCAND'(1));
        w_rest = r_mask & ~w_low;
    end

    always_comb begin
        w_slot = '0;
        w_rec  = 1'b0;
        for (int k = PEND_DEPTH - 1; k >= 0; k--) begin
            if (!r_pvalid[k]) begin
                w_slot = PA_BITS'(k);
                w_rec  = 1'b1;
            end
        end
    end

    always_comb begin
        if (i_cfg.cache_size == '0) begin
            w_lim = SIZE_BITS'(1);
        end else if (i_cfg.cache_size > SIZE_BITS'(CACHE_DEPTH)) begin
            w_lim = SIZE_BITS'(CACHE_DEPTH);
        end else begin
            w_lim = i_cfg.cache_size;
        end
    end

    assign w_ren   = (r_state == ST_SCAN) && (r_sidx < r_fill);
    assign w_raddr = r_head + r_sidx[CA_BITS-1:0];
    assign w_we    = (r_state == ST_DECIDE) && r_item.is_arrival && !r_found[0];
    assign w_waddr = r_head + r_fill[CA_BITS-1:0];

    assign w_age      = r_nstamp - r_pstamp[r_pidx];
    assign w_pmatch   = r_pvalid[r_pidx] && (r_pid[r_pidx] == r_item.id);
    assign w_better   = w_pmatch && (!r_bfound || (w_age > r_bage));
    assign w_scan_end = (r_pidx == PA_BITS'(PEND_DEPTH - 1));
    assign w_ans_last = (r_matches == PCNT_BITS'(1))
                        || (r_nans == PCNT_BITS'(MAX_RESULTS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_vld) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!w_ren && !r_rvld) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (r_item.is_arrival) begin
                    n_state = ST_PSCAN;
                end else if (r_found[0]) begin
                    n_state = ST_HIT;
                end else begin
                    n_state = ST_FETCH;
                end
            end
            ST_HIT: begin
                if (i_space) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FETCH: begin
                if (i_space && (w_rest == '0)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_PSCAN: begin
                if (w_scan_end) begin
                    n_state = ((r_matches == '0) && !w_pmatch) ? ST_IDLE : ST_ANSWER;
                end
            end
            ST_ANSWER: begin
                if (i_space) begin
                    n_state = w_ans_last ? ST_IDLE : ST_PSCAN;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_item    = r_item;
        n_head    = r_head;
        n_fill    = r_fill;
        n_hits    = r_hits;
        n_acc     = r_acc;
        n_sidx    = r_sidx;
        n_rvld    = 1'b0;
        n_found   = r_found;
        n_mask    = r_mask;
        n_full    = r_full;
        n_pvalid  = r_pvalid;
        n_nstamp  = r_nstamp;
        n_pidx    = r_pidx;
        n_best    = r_best;
        n_bage    = r_bage;
        n_bfound  = r_bfound;
        n_matches = r_matches;
        n_nans    = r_nans;
        o_take    = 1'b0;
        o_emit    = 1'b0;
        o_res     = '{kind: KIND_RESP, id: r_item.id, dest: r_item.client, full: 1'b0,
                      last: 1'b0, hits: r_hits, accesses: r_acc};
        unique case (r_state)
            ST_IDLE: begin
                o_take = 1'b1;
                if (i_vld) begin
                    n_item  = i_item;
                    n_sidx  = '0;
                    n_found = '0;
                    if (!i_item.is_arrival) begin
                        n_acc = r_acc + CNT_BITS'(1);
                    end
                end
            end
            ST_SCAN: begin
                n_rvld  = w_ren;
                n_found = r_found | w_hitv;
                if (w_ren) begin
                    n_sidx = r_sidx + FILL_BITS'(1);
                end
            end
            ST_DECIDE: begin
                n_pidx    = '0;
                n_bfound  = 1'b0;
                n_matches = '0;
                n_nans    = '0;
                if (r_item.is_arrival) begin
                    if (!r_found[0]) begin
                        if (r_fill >= w_lim) begin
                            n_head = r_head + CA_BITS'(1);
                        end else begin
                            n_fill = r_fill + FILL_BITS'(1);
                        end
                    end
                end else if (r_found[0]) begin
                    n_hits = r_hits + CNT_BITS'(1);
                end else begin
                    n_mask = w_mk;
                    n_full = !w_rec;
                    if (w_rec) begin
                        n_pvalid[w_slot] = 1'b1;
                        n_nstamp         = r_nstamp + STAMP_BITS'(1);
                    end
                end
            end
            ST_HIT: begin
                o_emit     = i_space;
                o_res.last = 1'b1;
            end
            ST_FETCH: begin
                o_emit     = i_space;
                o_res.kind = KIND_FETCH;
                o_res.dest = '0;
                o_res.full = r_full;
                o_res.last = (w_rest == '0);
                for (int k = 0; k < NCAND; k++) begin
                    if (w_low[k]) begin
                        o_res.id = w_cand[k];
                    end
                end
                if (i_space) begin
                    n_mask = w_rest;
                end
            end
            ST_PSCAN: begin
                n_pidx = r_pidx + PA_BITS'(1);
                if (w_pmatch) begin
                    n_matches = r_matches + PCNT_BITS'(1);
                end
                if (w_better) begin
                    n_best   = r_pidx;
                    n_bage   = w_age;
                    n_bfound = 1'b1;
                end
            end
            ST_ANSWER: begin
                o_emit     = i_space;
                o_res.dest = r_pcl[r_best];
                o_res.last = w_ans_last;
                if (i_space) begin
                    n_pvalid[r_best] = 1'b0;
                    n_nans           = r_nans + PCNT_BITS'(1);
                    n_pidx           = '0;
                    n_bfound         = 1'b0;
                    n_matches        = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '0;
            r_fill   <= '0;
            r_hits   <= '0;
            r_acc    <= '0;
            r_rvld   <= 1'b0;
            r_pvalid <= '0;
            r_nstamp <= '0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_fill   <= n_fill;
            r_hits   <= n_hits;
            r_acc    <= n_acc;
            r_rvld   <= n_rvld;
            r_pvalid <= n_pvalid;
            r_nstamp <= n_nstamp;
        end
        r_item    <= n_item;
        r_sidx    <= n_sidx;
        r_found   <= n_found;
        r_mask    <= n_mask;
        r_full    <= n_full;
        r_pidx    <= n_pidx;
        r_best    <= n_best;
        r_bage    <= n_bage;
        r_bfound  <= n_bfound;
        r_matches <= n_matches;
        r_nans    <= n_nans;
        if ((r_state == ST_DECIDE) && !r_item.is_arrival && !r_found[0] && w_rec) begin
            r_pid[w_slot]    <= r_item.id;
            r_pcl[w_slot]    <= r_item.client;
            r_pstamp[w_slot] <= r_nstamp;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_BITS'(CACHE_DEPTH))
        else $error("store fill beyond depth");

    a_emit_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> (r_state == ST_HIT || r_state == ST_FETCH || r_state == ST_ANSWER))
        else $error("result emitted outside an emitting state");

    a_fetch_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH) |-> (r_mask != '0))
        else $error("fetch state with nothing to issue");

    a_answer_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ANSWER) |-> (r_bfound && r_pvalid[r_best]))
        else $error("answer without a valid pending entry");

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_vld) |=> (r_state == ST_SCAN))
        else $error("accepted item did not start a store scan");

endmodule

// ===== design/fifo_content_cache_with_prefetch.sv =====
// Top level of the content cache controller with prefetch and pending table.
`timescale 1ns / 1ps
// Input queue: push/full carries action, item_id and client. Result queue:
// empty/pop presents kind, out_id, dest_client, pending_full, last and the
// hit and access counters; last marks the final result of an input item.
// Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index (0 cache_size,
// 1 prefetch_limit, 2 prefetch_span) and i_cfg_data; ready is always high.
// Items are worked one at a time. Each item scans the filled part of the id
// store through the single RAM read port, one entry per cycle. An arrival
// adds a walk over the 16-entry pending table per answered requester; an
// arrival with no pending requester gives no result.
// A two-entry input queue takes new items while the back end works, and a
// four-entry result queue holds results; when the receiver stalls the back
// end waits and the input queue fills, then full rises.
// Reset clears counters, store fill, pending valid bits and both queues and
// loads the register defaults (100, 101, 2). No clearing pass is needed.
module fifo_content_cache_with_prefetch
    import fccp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic                   i_action,
    input  logic [ID_BITS-1:0]     i_item_id,
    input  logic [CLIENT_BITS-1:0] i_client,
    output logic                   empty,
    input  logic                   pop,
    output logic                   o_kind,
    output logic [ID_BITS-1:0]     o_out_id,
    output logic [CLIENT_BITS-1:0] o_dest_client,
    output logic                   o_pending_full,
    output logic                   o_last,
    output logic [CNT_BITS-1:0]    o_hit_count,
    output logic [CNT_BITS-1:0]    o_access_count,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CIDX_BITS-1:0]   i_cfg_index,
    input  logic [CDATA_BITS-1:0]  i_cfg_data
);

    t_cfg    r_cfg;
    t_item   w_item;
    logic    w_vld, w_take, w_emit, w_space;
    t_result w_res, w_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{cache_size: CACHE_SIZE_RST, pf_limit: PF_LIMIT_RST,
                       pf_span: PF_SPAN_RST};
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CACHE_SIZE: r_cfg.cache_size <= i_cfg_data[SIZE_BITS-1:0];
                CFG_PF_LIMIT:   r_cfg.pf_limit   <= i_cfg_data[ID_BITS-1:0];
                CFG_PF_SPAN:    r_cfg.pf_span    <= i_cfg_data[SPAN_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    fccp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_action  (i_action),
        .i_item_id (i_item_id),
        .i_client  (i_client),
        .o_vld     (w_vld),
        .o_item    (w_item),
        .i_take    (w_take)
    );

    fccp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_vld   (w_vld),
        .i_item  (w_item),
        .o_take  (w_take),
        .o_emit  (w_emit),
        .o_res   (w_res),
        .i_space (w_space)
    );

    fccp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_put   (w_emit),
        .i_res   (w_res),
        .o_space (w_space),
        .empty   (empty),
        .pop     (pop),
        .o_res   (w_out)
    );

    assign o_kind         = w_out.kind;
    assign o_out_id       = w_out.id;
    assign o_dest_client  = w_out.dest;
    assign o_pending_full = w_out.full;
    assign o_last         = w_out.last;
    assign o_hit_count    = w_out.hits;
    assign o_access_count = w_out.accesses;

endmodule
